>>> rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, entry types and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 16;
	localparam int VALUE_BITS  = 32;
	localparam int CFG_BITS    = 5;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic [CFG_BITS-1:0] CAPACITY_RESET = CFG_BITS'(MAX_ENTRIES);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic load;    // capture a new transaction
		logic scan;    // examine the entry at idx
		logic commit;  // update the store and write the result register
		idx_t idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;  // result register can take a new result this cycle
	} dp_status_t;

endpackage

>>> rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences one transaction: capture, entry-by-entry scan, then commit
// once the result register is free.
// ----------------------------------------------------------------------------
module lkvc_ctrl
	import lkvc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	idx_t   idx_q;
	logic   last_idx;

	assign last_idx = (idx_q == IDX_W'(MAX_ENTRIES - 1));
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_COMMIT) && status.out_free;
		cmd.idx    = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_idx) begin
						state_q <= ST_COMMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					// hold until the previous result has been taken
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Entry store with age ranks, capacity register, scan trackers and the
// result register.
// ----------------------------------------------------------------------------
module lkvc_datapath
	import lkvc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	input  logic                   cfg_wen,
	input  logic [CFG_BITS-1:0]    cfg_wdata,
	input  logic                   command,
	input  logic [15:0]            lookup_key,
	input  logic signed [31:0]     write_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   key_found,
	output logic signed [31:0]     read_value
);

	logic [MAX_ENTRIES-1:0] valid_q;
	key_t                   key_q   [MAX_ENTRIES];
	value_t                 value_q [MAX_ENTRIES];
	idx_t                   age_q   [MAX_ENTRIES];
	cnt_t                   count_q;
	logic [CFG_BITS-1:0]    capacity_q;

	logic   cmd_q;
	key_t   req_key_q;
	value_t req_value_q;
	logic   hit_q;
	idx_t   hit_idx_q;
	logic   free_q;
	idx_t   free_idx_q;

	logic   out_valid_q;
	logic   found_q;
	value_t result_q;

	cnt_t                   cap_lim;
	logic                   evict_now;
	logic [MAX_ENTRIES-1:0] keep;
	logic                   scan_match;
	logic                   scan_free;
	idx_t                   hit_age;

	// capacity of zero acts as one, anything above the store size as the store size
	always_comb begin
		if (capacity_q == '0) begin
			cap_lim = CNT_W'(1);
		end else if (CNT_W'(capacity_q) > CNT_W'(MAX_ENTRIES)) begin
			cap_lim = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_lim = CNT_W'(capacity_q);
		end
	end

	assign evict_now = (count_q >= cap_lim);

	// ages are a permutation of 0..count-1, so evicting down to cap-1 entries
	// drops exactly the entries ranked cap-1 or older
	always_comb begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			keep[j] = valid_q[j] &&
				!(evict_now && ((CNT_W'(age_q[j]) + CNT_W'(1)) >= cap_lim));
		end
	end

	assign scan_match = valid_q[cmd.idx] && (key_q[cmd.idx] == req_key_q);
	assign scan_free  = !keep[cmd.idx];
	assign hit_age    = age_q[hit_idx_q];

	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign key_found  = found_q;
	assign read_value = signed'(result_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wen) begin
			capacity_q <= cfg_wdata;
		end
	end

	// transaction capture and scan trackers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q       <= command;
			req_key_q   <= lookup_key[KEY_BITS-1:0];
			req_value_q <= unsigned'(write_value);
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
		end else if (cmd.scan) begin
			if (!hit_q && scan_match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmd.idx;
			end
			if (!free_q && scan_free) begin
				free_q     <= 1'b1;
				free_idx_q <= cmd.idx;
			end
		end
	end

	// entry payload and ranks
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (hit_q) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (valid_q[j] && (age_q[j] < hit_age)) begin
						age_q[j] <= age_q[j] + 1'b1;
					end
				end
				age_q[hit_idx_q] <= '0;
				if (cmd_q == CMD_PUT) begin
					value_q[hit_idx_q] <= req_value_q;
				end
			end else if (cmd_q == CMD_PUT) begin
				for (int j = 0; j < MAX_ENTRIES; j++) begin
					if (keep[j]) begin
						age_q[j] <= age_q[j] + 1'b1;
					end
				end
				age_q[free_idx_q]   <= '0;
				key_q[free_idx_q]   <= req_key_q;
				value_q[free_idx_q] <= req_value_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit && !hit_q && (cmd_q == CMD_PUT)) begin
			valid_q             <= keep;
			valid_q[free_idx_q] <= 1'b1;
			count_q             <= evict_now ? cap_lim : count_q + 1'b1;
		end
	end

	// result register: set on commit, drop once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q <= hit_q;
			if (cmd_q == CMD_PUT) begin
				result_q <= req_value_q;
			end else if (hit_q) begin
				result_q <= value_q[hit_idx_q];
			end else begin
				result_q <= '1;
			end
		end
	end

endmodule

>>> rtl/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache unit
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one get or put transaction:
//   command, lookup_key and write_value. Output channel (out_valid /
//   out_stall) returns one result per transaction: key_found and read_value.
//   cfg_wen / cfg_wdata write the capacity register; write it only while idle.
//   Once a transaction is accepted, the key scan runs over all 16 entries,
//   then a commit writes the result register. A new transaction is not
//   accepted before the previous one has committed; the next one is
//   accepted in the cycle after the commit.
//   The scan walks the entry store one entry per cycle.
//   When out_stall holds a result in the output register, the next
//   transaction still runs its scan, then waits in commit until the result
//   register frees up. in_stall is high whenever a transaction is in flight.
//   Reset clears all valid bits, the entry count and the output valid, and
//   sets the capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
	import lkvc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [15:0]         lookup_key,
	input  logic signed [31:0]  write_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                key_found,
	output logic signed [31:0]  read_value
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lkvc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_found   (key_found),
		.read_value  (read_value)
	);

endmodule

>>> verif/lkvc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Watches the configuration port and both channels of the cache unit, keeps
// its own copy of the entry store with age ranks, predicts the result of each
// accepted transaction and compares every returned result in order.
// ----------------------------------------------------------------------------
module lkvc_checker
	import lkvc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                command,
	input  logic [15:0]         lookup_key,
	input  logic signed [31:0]  write_value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                key_found,
	input  logic signed [31:0]  read_value,
	output int                  fail_count,
	output int                  outstanding
);

	localparam value_t MISS_VALUE = '1;
	localparam int     REPORT_LIMIT = 10;

	typedef struct packed {
		logic   found;
		value_t value;
	} cache_result_t;

	logic                slot_valid [MAX_ENTRIES];
	key_t                slot_key   [MAX_ENTRIES];
	value_t              slot_value [MAX_ENTRIES];
	int unsigned         slot_age   [MAX_ENTRIES];
	int unsigned         slot_count;
	logic [CFG_BITS-1:0] capacity_reg;

	cache_result_t pending_results [$];
	int            errors = 0;

	task automatic clear_store();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_age[i]   = 0;
		end
		slot_count   = 0;
		capacity_reg = CAPACITY_RESET;
	endtask

	// Entries younger than slot idx age by one; idx becomes the newest.
	task automatic make_recent(input int idx);
		int unsigned rank;
		rank = slot_age[idx];
		for (int j = 0; j < MAX_ENTRIES; j++)
			if (slot_valid[j] && slot_age[j] < rank)
				slot_age[j]++;
		slot_age[idx] = 0;
	endtask

	task automatic evict_least_recent();
		bit done;
		done = 1'b0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (!done && slot_valid[j] && slot_age[j] + 1 == slot_count) begin
				slot_valid[j] = 1'b0;
				slot_count--;
				done = 1'b1;
			end
		end
	endtask

	task automatic predict_access(input logic cmd, input key_t key, input value_t val,
			output cache_result_t res);
		int          hit;
		int          free_slot;
		int unsigned limit;
		hit = -1;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (hit < 0 && slot_valid[i] && slot_key[i] == key)
				hit = i;
		if (cmd == CMD_GET) begin
			if (hit >= 0) begin
				make_recent(hit);
				res.found = 1'b1;
				res.value = slot_value[hit];
			end else begin
				res.found = 1'b0;
				res.value = MISS_VALUE;
			end
		end else if (hit >= 0) begin
			slot_value[hit] = val;
			make_recent(hit);
			res.found = 1'b1;
			res.value = val;
		end else begin
			// zero acts as one, anything above the store size as the store size
			limit = (capacity_reg == 0) ? 1 :
				(capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : capacity_reg;
			while (slot_count >= limit && slot_count > 0)
				evict_least_recent();
			free_slot = -1;
			for (int i = 0; i < MAX_ENTRIES; i++)
				if (free_slot < 0 && !slot_valid[i])
					free_slot = i;
			if (free_slot >= 0) begin
				for (int j = 0; j < MAX_ENTRIES; j++)
					if (slot_valid[j])
						slot_age[j]++;
				slot_valid[free_slot] = 1'b1;
				slot_key[free_slot]   = key;
				slot_value[free_slot] = val;
				slot_age[free_slot]   = 0;
				slot_count++;
			end
			res.found = 1'b0;
			res.value = val;
		end
	endtask

	task automatic compare_result();
		cache_result_t want;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("[checker] %0t: unexpected result found=%0b value=%h",
					$realtime, key_found, read_value);
		end else begin
			want = pending_results.pop_front();
			if (want.found !== key_found || want.value !== read_value) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("[checker] %0t: mismatch expected found=%0b value=%h, got found=%0b value=%h",
						$realtime, want.found, want.value, key_found, read_value);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cache_result_t res;
		if (!arst_n) begin
			clear_store();
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wen)
				capacity_reg = cfg_wdata;
			if (in_valid && !in_stall) begin
				predict_access(command, lookup_key, write_value, res);
				pending_results.push_back(res);
			end
			if (out_valid && !out_stall)
				compare_result();
			outstanding <= pending_results.size();
		end
		fail_count <= errors;
	end

endmodule

>>> verif/tb_lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache unit testbench
// Drives directed and random get/put transactions through a series of
// capacity settings with bursty input and a stalling receiver, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
	import lkvc_pkg::*;

	localparam int POOL_SIZE     = 40;
	localparam int PHASE_ITEMS   = 105;
	localparam int SETTLE_CYCLES = 24;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                command = CMD_GET;
	logic [15:0]         lookup_key = '0;
	logic signed [31:0]  write_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                key_found;
	logic signed [31:0]  read_value;

	int fail_count;
	int outstanding;

	logic [15:0]         key_pool [POOL_SIZE];
	logic [CFG_BITS-1:0] phase_caps [10] = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8,
		5'd0, 5'd16, 5'd2, 5'd17, 5'd12};
	int                  burst_left = 0;
	int                  pool_span = 20;

	lru_key_value_cache_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_found   (key_found),
		.read_value  (read_value)
	);

	lkvc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_found   (key_found),
		.read_value  (read_value),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one transaction and hold it until accepted, then pace the burst.
	task automatic offer(input logic cmd, input logic [15:0] key, input logic [31:0] val);
		int gap;
		in_valid    <= 1'b1;
		command     <= cmd;
		lookup_key  <= key;
		write_value <= val;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Drain all results, then let the unit go quiet before touching the register.
	task automatic write_capacity(input logic [CFG_BITS-1:0] cap);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		pool_span = ((cap == 0) ? 1 : (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap) + 4;
	endtask

	task automatic random_items(input int count);
		logic        cmd;
		logic [15:0] key;
		logic [31:0] val;
		int          pick;
		for (int k = 0; k < count; k++) begin
			cmd = ($urandom_range(0, 1) == 0) ? CMD_GET : CMD_PUT;
			// mostly keys from a small pool so that hits and evictions happen
			if ($urandom_range(0, 99) < 85)
				key = key_pool[$urandom_range(0, pool_span - 1)];
			else
				key = 16'($urandom);
			pick = $urandom_range(0, 15);
			case (pick)
				0:       val = 32'h8000_0000;
				1:       val = 32'h7FFF_FFFF;
				2:       val = '1;
				default: val = $urandom;
			endcase
			offer(cmd, key, val);
		end
	endtask

	// Receiver: segments of free flow, random stalls and periodic stalls,
	// with one long hold-off that backs up the unit.
	initial begin : receiver
		int cycle_no;
		int mode;
		int seg_left;
		int period;
		bit long_hold_done;
		cycle_no = 0;
		mode = 0;
		seg_left = 0;
		period = 2;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_no++;
			if (!long_hold_done && cycle_no == 5000) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				long_hold_done = 1'b1;
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 2);
				seg_left = $urandom_range(20, 200);
				period = $urandom_range(2, 9);
			end
			seg_left--;
			case (mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 99) < 40);
				default: out_stall <= ((cycle_no % period) < (period / 2));
			endcase
		end
	end

	initial begin
		#6_000_000;
		$display("[lru_key_value_cache_unit] ERROR");
		$finish;
	end

	initial begin
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = 16'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(5'd16);
		offer(CMD_GET, 16'h0000, 32'h0);
		offer(CMD_PUT, 16'h0000, 32'h7FFF_FFFF);
		offer(CMD_GET, 16'h0000, 32'h1234_5678);
		offer(CMD_PUT, 16'hFFFF, 32'h8000_0000);
		offer(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF);
		// stored value of all ones must still report a hit
		offer(CMD_PUT, 16'h0000, 32'hFFFF_FFFF);
		offer(CMD_GET, 16'h0000, 32'h0);
		offer(CMD_GET, 16'h1234, 32'h0);
		offer(CMD_PUT, 16'hAAAA, 32'h5555_5555);
		offer(CMD_PUT, 16'h5555, 32'hAAAA_AAAA);
		offer(CMD_GET, 16'h5555, 32'h0);

		// capacity one: each new key pushes out the last one; four entries
		// are still held, so the first put miss evicts down past them
		write_capacity(5'd1);
		offer(CMD_GET, 16'hAAAA, 32'h0);
		offer(CMD_PUT, 16'h0001, 32'h0000_0011);
		offer(CMD_PUT, 16'h0002, 32'h0000_0022);
		offer(CMD_GET, 16'h0001, 32'h0);
		offer(CMD_GET, 16'h0002, 32'h0);

		// zero behaves as one
		write_capacity(5'd0);
		offer(CMD_PUT, 16'h0003, 32'h0000_0033);
		offer(CMD_GET, 16'h0002, 32'h0);

		// out-of-range high behaves as the full store
		write_capacity(5'd31);
		offer(CMD_PUT, 16'h0004, 32'h0000_0044);
		offer(CMD_PUT, 16'h0005, 32'h0000_0055);
		offer(CMD_GET, 16'h0003, 32'h0);

		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			random_items(PHASE_ITEMS);
		end
		write_capacity(CFG_BITS'($urandom_range(0, 31)));
		random_items(PHASE_ITEMS);

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("[lru_key_value_cache_unit] OK");
		else
			$display("[lru_key_value_cache_unit] ERROR");
		$finish;
	end

endmodule
